// File: hw/rtl/lru_frame_replacer_top_defines.svh
// ----------------------------------------------------------------------------
// lru_frame_replacer_top_defines
// Assertion macros shared by the frame replacer RTL. Each macro expects a
// clock named clk and an active-low reset named arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef LRU_FRAME_REPLACER_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/lfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Operation codes and beat payload types of the LRU frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

	localparam int FUNC_W  = 2;
	localparam int FRAME_W = 6;
	localparam int COUNT_W = 7;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FRAME_W-1:0] frame_index;
	} lfr_req_t;

	typedef struct packed {
		logic               victim_found;
		logic [FRAME_W-1:0] victim_frame;
		logic [COUNT_W-1:0] tracked_count;
	} lfr_rsp_t;

endpackage

// File: hw/rtl/lru_frame_replacer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_top
// Least-recently-used replacer over the evictable buffer frames.
//
// Requests arrive as beats on in_valid/in_ready/in_data: victim, pin or unpin
// of one frame. Each request yields exactly one response beat on
// out_valid/out_ready/out_data carrying the victim result and the number of
// frames tracked afterwards.
// The recency order is a doubly linked list kept in one link memory (one
// read port, one masked write port). A request reads its frame's entry in the
// accept cycle, decodes in the next cycle while doing the first link write,
// then does each further link write in turn. The response is registered as
// the request finishes its link writes, and the next request is taken only
// after that; an unpin of an interior tracked frame takes the longest, set by
// four writes through the single write port.
// After reset the block clears the link memory, one entry per cycle, over
// all NUM_FRAMES entries (64 by default) with in_ready low.
// A response waits in an output register; the block holds its last step while
// that register is full and not taken, and takes a new request once the
// previous one has finished its writes.
// ----------------------------------------------------------------------------
`include "lru_frame_replacer_top_defines.svh"

module lru_frame_replacer_top
	import lfr_pkg::*;
#(
	parameter int NUM_FRAMES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lfr_req_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output lfr_rsp_t out_data
);

	localparam int IW = $clog2(NUM_FRAMES);
	localparam int CW = $clog2(NUM_FRAMES + 1);

	// Sequencer codes
	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_DEC  = 2'd2;
	localparam logic [1:0] S_WR   = 2'd3;

	typedef struct packed {
		logic          flag;
		logic [IW-1:0] newer;
		logic [IW-1:0] older;
	} entry_t;

	typedef struct packed {
		logic [IW-1:0] addr;
		logic          we_flag;
		logic          we_newer;
		logic          we_older;
		entry_t        data;
	} wreq_t;

	logic [1:0]    state_q;
	logic [IW-1:0] clr_idx_q;
	logic [FUNC_W-1:0] func_s1;
	logic [IW-1:0] frame_s1;
	logic          inrange_s1;
	entry_t        rdata_s1;
	logic [IW-1:0] mr_q;
	logic [IW-1:0] lr_q;
	logic [CW-1:0] cnt_q;
	wreq_t         slot_q [3];
	logic [2:0]    pend_q;
	lfr_rsp_t      res_q;
	logic          out_valid_q;
	lfr_rsp_t      out_q;

	entry_t        mem [NUM_FRAMES];

	logic [IW+5:0] req_ext;
	logic [IW-1:0] req_idx;
	logic          req_inrange;
	logic          accept;
	logic [IW-1:0] rd_addr;
	logic          fin_ok;

	logic [IW-1:0] fx;
	logic          is_v, is_p, is_u;
	logic          do_unlink, do_push;
	logic          at_mr, at_lr;
	logic [IW-1:0] mr_a, lr_a, mr_b, lr_b;
	logic [CW-1:0] cnt_a, cnt_b;
	wreq_t         w0, w1, w2, w3;
	logic [2:0]    pend_n;
	lfr_rsp_t      res_n;
	logic [CW+6:0] cnt_wide;
	logic [IW+5:0] vf_wide;
	logic          dec_go;

	logic [1:0]    sel;
	logic [2:0]    sel_hot;
	logic          wr_last;
	logic          wr_go;
	wreq_t         wreq;
	logic          finish;
	lfr_rsp_t      fin_rsp;

	function automatic logic has_we(input wreq_t r);
		has_we = r.we_flag | r.we_newer | r.we_older;
	endfunction

	// Request decode at the input
	assign req_ext     = {{IW{1'b0}}, in_data.frame_index};
	assign req_idx     = req_ext[IW-1:0];
	assign req_inrange = req_ext < (IW + 6)'(NUM_FRAMES);
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid & in_ready;
	assign rd_addr     = (in_data.func == FUNC_VICTIM) ? lr_q :
		(req_inrange ? req_idx : '0);
	assign fin_ok      = !out_valid_q || out_ready;

	// Decode one request from the entry read at accept
	always_comb begin
		is_v = (func_s1 == FUNC_VICTIM);
		is_p = (func_s1 == FUNC_PIN);
		is_u = (func_s1 == FUNC_UNPIN);
		fx   = is_v ? lr_q : frame_s1;
		do_unlink = (is_v && cnt_q != '0) ||
			((is_p || is_u) && inrange_s1 && rdata_s1.flag);
		do_push = is_u && inrange_s1;
		at_mr = (fx == mr_q);
		at_lr = (fx == lr_q);

		// unlink
		mr_a  = mr_q;
		lr_a  = lr_q;
		cnt_a = cnt_q;
		if (do_unlink) begin
			mr_a  = at_mr ? rdata_s1.older : mr_q;
			lr_a  = at_lr ? rdata_s1.newer : lr_q;
			cnt_a = cnt_q - 1'b1;
			if (cnt_a == '0) begin
				mr_a = '0;
				lr_a = '0;
			end
		end

		// push as most recent
		mr_b  = mr_a;
		lr_b  = lr_a;
		cnt_b = cnt_a;
		if (do_push) begin
			mr_b  = fx;
			lr_b  = (cnt_a == '0) ? fx : lr_a;
			cnt_b = cnt_a + 1'b1;
		end

		// link writes in list order
		w0 = '0;
		w0.addr       = rdata_s1.newer;
		w0.we_older   = do_unlink && !at_mr;
		w0.data.older = rdata_s1.older;

		w1 = '0;
		w1.addr       = rdata_s1.older;
		w1.we_newer   = do_unlink && !at_lr;
		w1.data.newer = rdata_s1.newer;

		w2 = '0;
		w2.addr       = mr_a;
		w2.we_newer   = do_push && (cnt_a != '0);
		w2.data.newer = fx;

		w3 = '0;
		w3.addr       = fx;
		w3.we_flag    = do_unlink || do_push;
		w3.we_newer   = do_push;
		w3.we_older   = do_push && (cnt_a != '0);
		w3.data.flag  = do_push;
		w3.data.newer = fx;
		w3.data.older = mr_a;

		pend_n = {has_we(w3), has_we(w2), has_we(w1)};

		cnt_wide = {7'b0, cnt_b};
		vf_wide  = {6'b0, fx};
		res_n.victim_found  = is_v && (cnt_q != '0);
		res_n.victim_frame  = res_n.victim_found ? vf_wide[5:0] : '0;
		res_n.tracked_count = cnt_wide[6:0];
	end

	assign dec_go = (state_q == S_DEC) && ((pend_n != '0) || fin_ok);

	// Pick the next pending slot write
	always_comb begin
		sel     = 2'd0;
		sel_hot = 3'b001;
		if (pend_q[0]) begin
			sel     = 2'd0;
			sel_hot = 3'b001;
		end else if (pend_q[1]) begin
			sel     = 2'd1;
			sel_hot = 3'b010;
		end else begin
			sel     = 2'd2;
			sel_hot = 3'b100;
		end
		wr_last = ((pend_q & ~sel_hot) == '0);
	end

	assign wr_go = (state_q == S_WR) && (!wr_last || fin_ok);

	// Write port select
	always_comb begin
		wreq = '0;
		case (state_q)
			S_CLR: begin
				wreq.addr     = clr_idx_q;
				wreq.we_flag  = 1'b1;
				wreq.we_newer = 1'b1;
				wreq.we_older = 1'b1;
			end
			S_DEC: begin
				if (dec_go) begin
					wreq = w0;
				end
			end
			S_WR: begin
				if (wr_go) begin
					wreq = slot_q[sel];
				end
			end
			default: begin
				wreq = '0;
			end
		endcase
	end

	assign finish  = (dec_go && pend_n == '0) || (wr_go && wr_last);
	assign fin_rsp = (state_q == S_DEC) ? res_n : res_q;

	// Link memory: masked write, registered read
	always_ff @(posedge clk) begin
		if (wreq.we_flag) begin
			mem[wreq.addr].flag <= wreq.data.flag;
		end
		if (wreq.we_newer) begin
			mem[wreq.addr].newer <= wreq.data.newer;
		end
		if (wreq.we_older) begin
			mem[wreq.addr].older <= wreq.data.older;
		end
		if (accept) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Capture request fields at accept, pending writes at decode and the response at finish
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= in_data.func;
			frame_s1   <= req_idx;
			inrange_s1 <= req_inrange;
		end
		if (dec_go) begin
			slot_q[0] <= w1;
			slot_q[1] <= w2;
			slot_q[2] <= w3;
			res_q     <= res_n;
		end
		if (finish) begin
			out_q <= fin_rsp;
		end
	end

	// Sequencer and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			mr_q        <= '0;
			lr_q        <= '0;
			cnt_q       <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (clr_idx_q == IW'(NUM_FRAMES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (dec_go) begin
						mr_q  <= mr_b;
						lr_q  <= lr_b;
						cnt_q <= cnt_b;
						if (pend_n == '0) begin
							state_q <= S_IDLE;
						end else begin
							pend_q  <= pend_n;
							state_q <= S_WR;
						end
					end
				end
				S_WR: begin
					if (wr_go) begin
						pend_q <= pend_q & ~sel_hot;
						if (wr_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// hold the response until taken
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	`LFR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(NUM_FRAMES), "tracked count above frame count")
	`LFR_ASSERT_NOW(a_empty_ends, cnt_q == '0, mr_q == '0 && lr_q == '0, "empty list with live ends")
	`LFR_ASSERT_NEXT(a_accept_dec, accept, state_q == S_DEC, "accepted beat not decoded next cycle")
	`LFR_ASSERT_NOW(a_pend_in_wr, state_q != S_WR, pend_q == '0, "pending writes outside write phase")

endmodule
